// ===== design/ucs_pkg.sv =====
`default_nettype none

package ucs_pkg;

    localparam int MAX_LEN = 4096;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int OFF_W   = 13;
    localparam int PORT_W  = 16;
    localparam int ACC_W   = 17;
    localparam int CNT_W   = 3;
    localparam int STAT_W  = 3;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [CNT_W-1:0] PORT_DIGITS = CNT_W'(5);
    localparam logic [CNT_W-1:0] PORT_SAT    = CNT_W'(6);
    localparam logic [ACC_W-1:0] PORT_MAX    = ACC_W'(65535);

    localparam logic [STAT_W-1:0] ST_OK         = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_BAD_SEP    = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_EMPTY_REST = STAT_W'(2);
    localparam logic [STAT_W-1:0] ST_PORT_CHAR  = STAT_W'(3);
    localparam logic [STAT_W-1:0] ST_PORT_RANGE = STAT_W'(4);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  scheme_chars;
        logic [OFF_W-1:0]  authority_start;
        logic [OFF_W-1:0]  authority_len;
        logic [OFF_W-1:0]  host_len;
        logic [PORT_W-1:0] port_value;
        logic [OFF_W-1:0]  path_start;
        logic [OFF_W-1:0]  path_len;
        logic              path_is_default;
        logic [OFF_W-1:0]  query_start;
        logic [OFF_W-1:0]  query_chars;
        logic [OFF_W-1:0]  path_query_start;
    } res_t;

endpackage

`default_nettype wire

// ===== design/ucs_parse.sv =====
`default_nettype none

module ucs_parse import ucs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] char_in,
    input  wire logic       last,
    output logic            res_wr,
    output res_t            res
);

    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_COLON  = 3'd1;
    localparam logic [2:0] PH_SLASH1 = 3'd2;
    localparam logic [2:0] PH_SCHEME = 3'd3;
    localparam logic [2:0] PH_PLAIN  = 3'd4;
    localparam logic [2:0] PH_BADSEP = 3'd5;

    // per-rest scan state; snap_* is the port state frozen at the first '?'
    typedef struct packed {
        logic             sl_found;
        logic [IDX_W-1:0] sl_pos;
        logic             qm_found;
        logic [IDX_W-1:0] qm_pos;
        logic             qq_found;
        logic [IDX_W-1:0] qq_pos;
        logic             pc_found;
        logic [IDX_W-1:0] pc_pos;
        logic             bad;
        logic [CNT_W-1:0] cnt;
        logic [ACC_W-1:0] acc;
        logic             snap_pc;
        logic             snap_bad;
        logic [CNT_W-1:0] snap_cnt;
        logic [ACC_W-1:0] snap_acc;
    } trk_t;

    function automatic trk_t trk_step(input trk_t t, input logic [7:0] b,
                                      input logic [IDX_W-1:0] p);
        trk_t n;
        logic dig;
        n   = t;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        if (!t.sl_found)
        begin
            if (b == CH_SLASH)
            begin
                n.sl_found = 1'b1;
                n.sl_pos   = p;
            end
            else
            begin
                if (b == CH_QMARK && !t.qm_found)
                begin
                    n.qm_found = 1'b1;
                    n.qm_pos   = p;
                    n.snap_pc  = t.pc_found;
                    n.snap_bad = t.bad;
                    n.snap_cnt = t.cnt;
                    n.snap_acc = t.acc;
                end
                if (t.pc_found)
                begin
                    if (!dig)
                    begin
                        n.bad = 1'b1;
                    end
                    if (t.cnt < PORT_SAT)
                    begin
                        n.cnt = t.cnt + CNT_W'(1);
                    end
                    if (t.cnt < PORT_DIGITS)
                    begin
                        n.acc = (t.acc << 3) + (t.acc << 1)
                              + {{(ACC_W-4){1'b0}}, b[3:0]};
                    end
                end
                else if (b == CH_COLON)
                begin
                    n.pc_found = 1'b1;
                    n.pc_pos   = p;
                end
            end
        end
        else if (b == CH_QMARK && !t.qq_found)
        begin
            n.qq_found = 1'b1;
            n.qq_pos   = p;
        end
        return n;
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] rest_reg, rest_next;
    trk_t             trk_reg, trk_next;

    logic             byte_ok;
    logic [IDX_W-1:0] p;
    logic             restart;
    logic [2:0]       ph_new;
    logic [POS_W-1:0] rest_new;
    trk_t             trk_new;
    logic [POS_W-1:0] len;

    always_comb
    begin
        byte_ok = pos_reg < POS_W'(MAX_LEN);
        p       = pos_reg[IDX_W-1:0];
        restart = 1'b0;
        ph_new  = phase_reg;
        col_next = col_reg;
        rest_new = rest_reg;
        if (take && byte_ok)
        begin
            unique case (phase_reg) inside
                PH_SEARCH:
                begin
                    if (char_in == CH_COLON)
                    begin
                        ph_new   = PH_COLON;
                        col_next = p;
                    end
                end
                PH_COLON:
                begin
                    ph_new = (char_in == CH_SLASH) ? PH_SLASH1 : PH_PLAIN;
                end
                PH_SLASH1:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        ph_new   = PH_SCHEME;
                        restart  = 1'b1;
                        rest_new = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        ph_new = PH_BADSEP;
                    end
                end
                PH_SCHEME, PH_PLAIN, PH_BADSEP:
                begin
                    ph_new = phase_reg;
                end
                default:
                begin
                    ph_new = PH_BADSEP;
                end
            endcase
        end
        if (!(take && byte_ok))
        begin
            trk_new = trk_reg;
        end
        else if (restart)
        begin
            trk_new = '0;
        end
        else
        begin
            trk_new = trk_step(trk_reg, char_in, p);
        end
        len = byte_ok ? pos_reg + POS_W'(1) : pos_reg;

        if (take && last)
        begin
            pos_next   = '0;
            phase_next = PH_SEARCH;
            trk_next   = '0;
            rest_next  = '0;
        end
        else
        begin
            pos_next   = (take && byte_ok) ? pos_reg + POS_W'(1) : pos_reg;
            phase_next = ph_new;
            trk_next   = trk_new;
            rest_next  = rest_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_SEARCH;
            col_reg   <= '0;
            rest_reg  <= '0;
            trk_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            col_reg   <= col_next;
            rest_reg  <= rest_next;
            trk_reg   <= trk_next;
        end
    end

    // closing the URI: evaluated on the state that includes the last byte
    logic [POS_W-1:0]  r;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  host_end;
    logic              use_snap;
    logic              pc_here;
    logic              pbad;
    logic [CNT_W-1:0]  pcnt;
    logic [ACC_W-1:0]  pacc;
    logic [STAT_W-1:0] st;
    res_t              f;

    always_comb
    begin
        r        = rest_new;
        use_snap = !trk_new.sl_found && trk_new.qm_found;
        pc_here  = use_snap ? trk_new.snap_pc  : trk_new.pc_found;
        pbad     = use_snap ? trk_new.snap_bad : trk_new.bad;
        pcnt     = use_snap ? trk_new.snap_cnt : trk_new.cnt;
        pacc     = use_snap ? trk_new.snap_acc : trk_new.acc;
        if (trk_new.sl_found)
        begin
            end_pos = POS_W'(trk_new.sl_pos);
        end
        else if (trk_new.qm_found)
        begin
            end_pos = POS_W'(trk_new.qm_pos);
        end
        else
        begin
            end_pos = len;
        end
        host_end = pc_here ? POS_W'(trk_new.pc_pos) : end_pos;

        st = ST_OK;
        if (ph_new == PH_SLASH1 || ph_new == PH_BADSEP)
        begin
            st = ST_BAD_SEP;
        end
        else if (r >= len)
        begin
            st = ST_EMPTY_REST;
        end
        else if (pc_here)
        begin
            if (pbad)
            begin
                st = ST_PORT_CHAR;
            end
            else if (pcnt > PORT_DIGITS || pacc > PORT_MAX)
            begin
                st = ST_PORT_RANGE;
            end
        end

        f                 = '0;
        f.scheme_chars    = (ph_new == PH_SCHEME) ? OFF_W'(col_next) : '0;
        f.authority_start = OFF_W'(r);
        f.authority_len   = OFF_W'(end_pos - r);
        f.host_len        = OFF_W'(host_end - r);
        f.port_value      = pc_here ? pacc[PORT_W-1:0] : '0;
        if (trk_new.sl_found)
        begin
            f.path_start       = OFF_W'(trk_new.sl_pos);
            f.path_query_start = OFF_W'(trk_new.sl_pos);
            if (trk_new.qq_found)
            begin
                f.path_len    = OFF_W'(POS_W'(trk_new.qq_pos) - POS_W'(trk_new.sl_pos));
                f.query_start = OFF_W'(POS_W'(trk_new.qq_pos) + POS_W'(1));
                f.query_chars = OFF_W'(len - POS_W'(trk_new.qq_pos) - POS_W'(1));
            end
            else
            begin
                f.path_len = OFF_W'(len - POS_W'(trk_new.sl_pos));
            end
        end
        else if (trk_new.qm_found)
        begin
            f.path_query_start = OFF_W'(trk_new.qm_pos);
            f.query_start      = OFF_W'(POS_W'(trk_new.qm_pos) + POS_W'(1));
            f.query_chars      = OFF_W'(len - POS_W'(trk_new.qm_pos) - POS_W'(1));
        end
        else
        begin
            f.path_len        = OFF_W'(1);
            f.path_is_default = 1'b1;
        end

        if (st != ST_OK)
        begin
            f = '0;
        end
        f.status = st;
        res      = f;
        res_wr   = take && last;
    end

endmodule

`default_nettype wire

// ===== design/ucs_res_buf.sv =====
`default_nettype none

module ucs_res_buf import ucs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire res_t wr_data,
    output logic      space,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output res_t      rd_data
);

    res_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       rd;

    always_comb
    begin
        space       = cnt_reg != 2'd2;
        rd_valid    = cnt_reg != 2'd0;
        rd          = rd_valid && rd_ready;
        rd_data     = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/uri_component_splitter_core.sv =====
// Channel   Handshake                  Payload                     Transfer
// byte      byte_valid / byte_ready    char_in, last               one URI byte
// result    res_valid  / res_ready     status .. path_query_start  one parse result
//
// One byte per cycle while ready; each byte updates the scan registers in a single pass.
// The result of a last byte is registered in a two-entry output buffer before it is shown.
// byte_ready drops only while both buffer entries hold untaken results.
// Reset clears the scan state and the buffer; bytes beyond 4096 are dropped until last.
`default_nettype none

module uri_component_splitter_core import ucs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_ready,
    input  wire logic [7:0]        char_in,
    input  wire logic              last,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [STAT_W-1:0]      status,
    output logic [OFF_W-1:0]       scheme_chars,
    output logic [OFF_W-1:0]       authority_start,
    output logic [OFF_W-1:0]       authority_len,
    output logic [OFF_W-1:0]       host_len,
    output logic [PORT_W-1:0]      port_value,
    output logic [OFF_W-1:0]       path_start,
    output logic [OFF_W-1:0]       path_len,
    output logic                   path_is_default,
    output logic [OFF_W-1:0]       query_start,
    output logic [OFF_W-1:0]       query_chars,
    output logic [OFF_W-1:0]       path_query_start
);

    logic take;
    logic res_wr;
    res_t res_new;
    res_t res_out;

    assign take = byte_valid && byte_ready;

    ucs_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .char_in (char_in),
        .last    (last),
        .res_wr  (res_wr),
        .res     (res_new)
    );

    ucs_res_buf u_res_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (res_wr),
        .wr_data  (res_new),
        .space    (byte_ready),
        .rd_valid (res_valid),
        .rd_ready (res_ready),
        .rd_data  (res_out)
    );

    assign status           = res_out.status;
    assign scheme_chars     = res_out.scheme_chars;
    assign authority_start  = res_out.authority_start;
    assign authority_len    = res_out.authority_len;
    assign host_len         = res_out.host_len;
    assign port_value       = res_out.port_value;
    assign path_start       = res_out.path_start;
    assign path_len         = res_out.path_len;
    assign path_is_default  = res_out.path_is_default;
    assign query_start      = res_out.query_start;
    assign query_chars      = res_out.query_chars;
    assign path_query_start = res_out.path_query_start;

endmodule

`default_nettype wire

// ===== design/ucs_checker.sv =====
`default_nettype none

module ucs_checker import ucs_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              byte_ready,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [STAT_W-1:0] status,
    input wire logic [OFF_W-1:0]  scheme_chars,
    input wire logic [OFF_W-1:0]  authority_start,
    input wire logic [OFF_W-1:0]  authority_len,
    input wire logic [OFF_W-1:0]  host_len,
    input wire logic [PORT_W-1:0] port_value,
    input wire logic [OFF_W-1:0]  path_start,
    input wire logic [OFF_W-1:0]  path_len,
    input wire logic              path_is_default,
    input wire logic [OFF_W-1:0]  query_start,
    input wire logic [OFF_W-1:0]  query_chars,
    input wire logic [OFF_W-1:0]  path_query_start
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(port_value)
            && $stable(authority_start) && $stable(path_len))
        else $error("result changed while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> res_valid)
        else $error("byte side stalled with no result pending");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_OK |-> scheme_chars == '0 && authority_len == '0
            && host_len == '0 && port_value == '0 && path_len == '0
            && query_start == '0 && path_query_start == '0 && !path_is_default)
        else $error("error result carries nonzero fields");

    a_default_path: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && path_is_default |-> path_len == OFF_W'(1) && path_start == '0
            && path_query_start == '0 && query_chars == '0)
        else $error("implied path with inconsistent fields");

    a_scheme_gap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_OK && scheme_chars != '0
            |-> authority_start == scheme_chars + OFF_W'(3))
        else $error("authority does not follow scheme separator");

endmodule

bind uri_component_splitter_core ucs_checker u_ucs_checker (.*);

`default_nettype wire

// ===== sim/uri_result_checker.sv =====
`default_nettype none

module uri_result_checker import ucs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    input  wire logic              byte_ready,
    input  wire logic [7:0]        char_in,
    input  wire logic              last,
    input  wire logic              res_valid,
    input  wire logic              res_ready,
    input  wire logic [STAT_W-1:0] status,
    input  wire logic [OFF_W-1:0]  scheme_chars,
    input  wire logic [OFF_W-1:0]  authority_start,
    input  wire logic [OFF_W-1:0]  authority_len,
    input  wire logic [OFF_W-1:0]  host_len,
    input  wire logic [PORT_W-1:0] port_value,
    input  wire logic [OFF_W-1:0]  path_start,
    input  wire logic [OFF_W-1:0]  path_len,
    input  wire logic              path_is_default,
    input  wire logic [OFF_W-1:0]  query_start,
    input  wire logic [OFF_W-1:0]  query_chars,
    input  wire logic [OFF_W-1:0]  path_query_start,
    output int                     errors,
    output int                     pending,
    output int                     bytes_seen,
    output int                     results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  uri_mem [MAX_LEN];
    int unsigned fill;
    res_t        split_q[$];
    res_t        got;
    res_t        want;

    initial
    begin
        errors       = 0;
        pending      = 0;
        bytes_seen   = 0;
        results_seen = 0;
        fill         = 0;
    end

    function automatic int unsigned find_char(int unsigned from, int unsigned to,
                                              logic [7:0] ch);
        int unsigned i;
        for (i = from; i < to && i < MAX_LEN; i++)
            if (uri_mem[i] == ch)
                return i;
        return to;
    endfunction

    function automatic res_t split_uri(int unsigned len);
        res_t              r;
        logic [STAT_W-1:0] st;
        int unsigned       col, rest, sl, qm, stop, pc, plen, i, pval;
        r    = '0;
        st   = ST_OK;
        rest = 0;
        col  = find_char(0, len, CH_COLON);
        if (col + 1 < len && uri_mem[col + 1] == CH_SLASH)
        begin
            if (col + 2 < len && uri_mem[col + 2] == CH_SLASH)
            begin
                r.scheme_chars = OFF_W'(col);
                rest = col + 3;
            end
            else
                st = ST_BAD_SEP;
        end
        if (st == ST_OK && rest >= len)
            st = ST_EMPTY_REST;
        if (st == ST_OK)
        begin
            sl = find_char(rest, len, CH_SLASH);
            qm = find_char(rest, len, CH_QMARK);
            r.authority_start = OFF_W'(rest);
            if (sl == len && qm == len)
            begin
                stop = len;
                r.path_len = OFF_W'(1);
                r.path_is_default = 1'b1;
            end
            else if (sl < len)
            begin
                stop = sl;
                r.path_start = OFF_W'(sl);
                r.path_query_start = OFF_W'(sl);
                qm = find_char(sl, len, CH_QMARK);
                if (qm == len)
                    r.path_len = OFF_W'(len - sl);
                else
                begin
                    r.path_len = OFF_W'(qm - sl);
                    r.query_start = OFF_W'(qm + 1);
                    r.query_chars = OFF_W'(len - qm - 1);
                end
            end
            else
            begin
                stop = qm;
                r.path_query_start = OFF_W'(qm);
                r.query_start = OFF_W'(qm + 1);
                r.query_chars = OFF_W'(len - qm - 1);
            end
            r.authority_len = OFF_W'(stop - rest);
            if (stop > rest)
            begin
                pc = find_char(rest, stop, CH_COLON);
                if (pc == stop)
                    r.host_len = OFF_W'(stop - rest);
                else
                begin
                    r.host_len = OFF_W'(pc - rest);
                    plen = stop - pc - 1;
                    for (i = pc + 1; i < stop; i++)
                        if (uri_mem[i] < CH_ZERO || uri_mem[i] > CH_NINE)
                        begin
                            st = ST_PORT_CHAR;
                            break;
                        end
                    if (st == ST_OK && plen > 5)
                        st = ST_PORT_RANGE;
                    if (st == ST_OK)
                    begin
                        pval = 0;
                        for (i = pc + 1; i < stop; i++)
                            pval = pval * 10 + (uri_mem[i] - CH_ZERO);
                        if (pval > 65535)
                            st = ST_PORT_RANGE;
                        else
                            r.port_value = PORT_W'(pval);
                    end
                end
            end
        end
        if (st != ST_OK)
            r = '0;
        r.status = st;
        return r;
    endfunction

    task automatic cmp(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                bytes_seen++;
                if (fill < MAX_LEN)
                begin
                    uri_mem[fill] = char_in;
                    fill++;
                end
                if (last)
                begin
                    split_q.push_back(split_uri(fill));
                    fill = 0;
                end
            end
            if (res_valid && res_ready)
            begin
                got = {status, scheme_chars, authority_start, authority_len, host_len,
                       port_value, path_start, path_len, path_is_default, query_start,
                       query_chars, path_query_start};
                if (split_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result transfer, status %0d",
                             $time, got.status);
                end
                else
                begin
                    want = split_q.pop_front();
                    results_seen++;
                    cmp("status", want.status, got.status);
                    cmp("scheme_chars", want.scheme_chars, got.scheme_chars);
                    cmp("authority_start", want.authority_start, got.authority_start);
                    cmp("authority_len", want.authority_len, got.authority_len);
                    cmp("host_len", want.host_len, got.host_len);
                    cmp("port_value", want.port_value, got.port_value);
                    cmp("path_start", want.path_start, got.path_start);
                    cmp("path_len", want.path_len, got.path_len);
                    cmp("path_is_default", want.path_is_default, got.path_is_default);
                    cmp("query_start", want.query_start, got.query_start);
                    cmp("query_chars", want.query_chars, got.query_chars);
                    cmp("path_query_start", want.path_query_start, got.path_query_start);
                end
            end
            pending = split_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/uri_component_splitter_core_test.sv =====
`default_nettype none

module uri_component_splitter_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ucs_pkg::*;

    typedef logic [7:0] bytes_t[$];

    localparam string ALPHA  = "abcxyzAZ";
    localparam string HOSTC  = "abz09.-";
    localparam string PATHC  = "az09/:.-_";
    localparam string QUERYC = "az09=&/?:";
    localparam string DIGITS = "0123456789";
    localparam string NOISE  = ":/?09aZ";

    logic              clk;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_ready;
    logic [7:0]        char_in;
    logic              last;
    logic              res_valid;
    logic              res_ready;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  scheme_chars;
    logic [OFF_W-1:0]  authority_start;
    logic [OFF_W-1:0]  authority_len;
    logic [OFF_W-1:0]  host_len;
    logic [PORT_W-1:0] port_value;
    logic [OFF_W-1:0]  path_start;
    logic [OFF_W-1:0]  path_len;
    logic              path_is_default;
    logic [OFF_W-1:0]  query_start;
    logic [OFF_W-1:0]  query_chars;
    logic [OFF_W-1:0]  path_query_start;

    int errors;
    int pending;
    int bytes_seen;
    int results_seen;

    int     tx_idle_pct;
    int     rx_idle_pct;
    int     rx_hold;
    bytes_t uri_buf;

    uri_component_splitter_core dut (.*);

    uri_result_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("uri_component_splitter_core_test: errors");
        $finish;
    end

    // result side; a nonzero rx_hold holds ready low while it counts down to zero
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                res_ready = 1'b0;
                rx_hold--;
            end
            else
                res_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    task automatic put(input string s);
        for (int i = 0; i < s.len(); i++)
            uri_buf.push_back(s[i]);
    endtask

    task automatic put_run(input string set, input int n);
        repeat (n) uri_buf.push_back(pick(set));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        char_in    = b;
        last       = fin;
        do @(posedge clk); while (!byte_ready);
        @(negedge clk);
    endtask

    task automatic send_uri();
        for (int i = 0; i < uri_buf.size(); i++)
            send_byte(uri_buf[i], i == uri_buf.size() - 1);
        uri_buf.delete();
        byte_valid = 1'b0;
    endtask

    task automatic send_str(input string s);
        put(s);
        send_uri();
    endtask

    task automatic put_port();
        case ($urandom_range(5))
            0: ;
            1: put($sformatf("%0d", $urandom_range(65535)));
            2: put("65535");
            3: put("65536");
            4: put_run(DIGITS, $urandom_range(7, 5));
            default: put($sformatf("%05d", $urandom_range(99999)));
        endcase
    endtask

    task automatic make_random_uri();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            if ($urandom_range(4) != 0)
            begin
                put_run(ALPHA, $urandom_range(6, 1));
                put("://");
            end
            put_run(HOSTC, $urandom_range(8));
            if ($urandom_range(1))
            begin
                put(":");
                put_port();
            end
            if ($urandom_range(9) < 6)
            begin
                put("/");
                put_run(PATHC, $urandom_range(8));
            end
            if ($urandom_range(9) < 4)
            begin
                put("?");
                put_run(QUERYC, $urandom_range(6));
            end
            if (uri_buf.size() == 0)
                put_run(HOSTC, 1);
        end
        else if (kind < 85)
        begin
            put_run(ALPHA, $urandom_range(5, 1));
            case ($urandom_range(4))
                0:
                begin
                    put(":/");
                    put_run(PATHC, $urandom_range(4));
                end
                1: put("://");
                2:
                begin
                    put("://");
                    put_run(HOSTC, $urandom_range(4));
                    put(":");
                    put_run(DIGITS, $urandom_range(3));
                    put_run(ALPHA, 1);
                    put_run(DIGITS, $urandom_range(4));
                    if ($urandom_range(1))
                        put("/p");
                end
                3:
                begin
                    put("://h:");
                    put_run(DIGITS, $urandom_range(9, 6));
                end
                default: put(":");
            endcase
        end
        else
        begin
            n = $urandom_range(12, 1);
            repeat (n)
                if ($urandom_range(1))
                    uri_buf.push_back(pick(NOISE));
                else
                    uri_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int mode_bytes;
        int mode_uris;
        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        char_in     = 8'h00;
        last        = 1'b0;
        rx_hold     = 0;
        tx_idle_pct = 34;
        rx_idle_pct = 49;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_str("a");
        send_str(":");
        send_str("ab:");
        send_str("h://");
        send_str("h:/x");
        send_str("h:/");
        send_str("h://x:");
        send_str("h://x:65535/");
        send_str("h://x:65536");
        send_str("h://x:123456");
        send_str("h://x:12a");
        send_str("h://x:1a23456");
        send_str("h://x:00000?");
        send_str("h://hp/p:q/?a?b");
        send_str("h://hp?q/x");
        send_str("host:80?x");
        send_str("/path");
        send_str("?");
        send_str("a:b");
        uri_buf.push_back(8'hFF);
        uri_buf.push_back(8'h00);
        put("://h:1");
        send_uri();
        uri_buf.push_back(8'h00);
        uri_buf.push_back(8'hFF);
        send_uri();

        // long result stall while bytes keep coming
        tx_idle_pct = 0;
        rx_hold = 300;
        repeat (6)
        begin
            put_run(ALPHA, $urandom_range(3, 1));
            send_uri();
        end
        wait (pending == 0);
        @(negedge clk);

        for (int m = 0; m < 3; m++)
        begin
            tx_idle_pct = (m == 0) ? 34 : (m == 1) ? 49 : 0;
            rx_idle_pct = (m == 0) ? 49 : (m == 1) ? 34 : 0;
            mode_bytes = 0;
            mode_uris  = 0;
            while (mode_bytes < 180 || mode_uris < 16)
            begin
                make_random_uri();
                mode_bytes += uri_buf.size();
                mode_uris++;
                send_uri();
            end
        end

        wait (pending == 0);
        repeat (10) @(posedge clk);
        $display("covered %0d bytes in %0d URIs, scheme, port and query corner cases included",
                 bytes_seen, results_seen);
        $display("idle mixes 34/49, 49/34 and none, one long result stall, one drain pause");
        if (errors == 0)
            $display("uri_component_splitter_core_test: clean");
        else
            $display("uri_component_splitter_core_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
